/* hw/rtl/cdss_pkg.sv */
// Shared types, constants and the month length table for the clock setting sequencer.
package cdss_pkg;

  // Button events carried by one input item.
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_INCREASE = 2'd2,
    OP_NEXT     = 2'd3
  } op_t;

  // Field currently being edited.
  typedef enum logic [2:0] {
    STG_YEAR   = 3'd0,
    STG_MONTH  = 3'd1,
    STG_DAY    = 3'd2,
    STG_HOUR   = 3'd3,
    STG_MINUTE = 3'd4
  } stage_t;

  localparam int unsigned CUR_YEAR_W = 14;
  localparam int unsigned YEAR_W     = 7;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned FULL_YEAR_W = 12;

  localparam logic [YEAR_W-1:0]      YEAR_MAX    = 7'd99;
  localparam logic [YEAR_W:0]        YEAR_MOD    = 8'd100;
  localparam logic [MONTH_W-1:0]     MONTH_MAX   = 4'd12;
  localparam logic [HOUR_W-1:0]      HOUR_MAX    = 5'd23;
  localparam logic [MINUTE_W-1:0]    MINUTE_MAX  = 6'd59;
  localparam logic [FULL_YEAR_W-1:0] YEAR_BASE   = 12'd2000;

  // Reciprocal of 100 scaled by 2^19, rounded down so the quotient
  // estimate is never too large.
  localparam int unsigned        MOD100_SHIFT = 19;
  localparam logic [12:0]        MOD100_RECIP = 13'd5242;

  // Days in a month; leap years are those with the two-digit year divisible
  // by four. A month code outside 1..12 is given 31 days.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic [YEAR_W-1:0]  year);
    logic [DAY_W-1:0] len;
    begin
      unique case (month)
        4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
        4'd4,
        4'd6,
        4'd9,
        4'd11:   len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

/* hw/rtl/cdss_mod100.sv */
// Reduces a 14-bit calendar year to its last two decimal digits.
module cdss_mod100 (
  input  logic [cdss_pkg::CUR_YEAR_W-1:0] year_in,
  output logic [cdss_pkg::YEAR_W-1:0]     year_out
);
  import cdss_pkg::*;

  logic [CUR_YEAR_W+12:0] prod;
  logic [7:0]             quot;
  logic [CUR_YEAR_W:0]    quot_x100;
  logic [CUR_YEAR_W:0]    rem_raw;
  logic [7:0]             rem_fix;

  // The quotient estimate is exact or one short, so the raw remainder
  // lies below 200 and one conditional subtract finishes the job.
  always_comb begin
    prod      = year_in * MOD100_RECIP;
    quot      = prod[MOD100_SHIFT+7:MOD100_SHIFT];
    quot_x100 = {1'b0, quot, 6'd0} + {2'b0, quot, 5'd0} + {5'b0, quot, 2'd0};
    rem_raw   = {1'b0, year_in} - quot_x100;
    rem_fix   = (rem_raw[7:0] >= YEAR_MOD) ? (rem_raw[7:0] - YEAR_MOD) : rem_raw[7:0];
    year_out  = rem_fix[YEAR_W-1:0];
  end

endmodule

/* hw/rtl/clock_date_setting_sequencer.sv */
// Top level of the clock date and time setting sequencer.
//
//   Channel  Ports                       Direction  Item
//   input    in_valid / in_stall         in         one button event plus current date/time
//   result   out_valid / out_stall       out        edit state after the event, commit flag
//
// The current year is reduced to two digits on its way into the input register.
// An accepted item is held in the input register and then updates the edit
// registers, which drive the result ports directly. A new item can be accepted
// in every cycle while in_stall is low. Reset puts the machine in normal mode at
// the year stage with the date 00-01-01 00:00 and empties both stages. A stall on
// the result side holds the result and the edit registers; the input register can
// still take one more item, after which in_stall rises.
module clock_date_setting_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic [cdss_pkg::CUR_YEAR_W-1:0]    in_cur_year,
  input  logic [cdss_pkg::MONTH_W-1:0]       in_cur_month,
  input  logic [cdss_pkg::DAY_W-1:0]         in_cur_day,
  input  logic [cdss_pkg::HOUR_W-1:0]        in_cur_hour,
  input  logic [cdss_pkg::MINUTE_W-1:0]      in_cur_minute,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_setup_active,
  output logic [2:0]                         out_stage,
  output logic [cdss_pkg::YEAR_W-1:0]        out_edit_year,
  output logic [cdss_pkg::MONTH_W-1:0]       out_edit_month,
  output logic [cdss_pkg::DAY_W-1:0]         out_edit_day,
  output logic [cdss_pkg::HOUR_W-1:0]        out_edit_hour,
  output logic [cdss_pkg::MINUTE_W-1:0]      out_edit_minute,
  output logic                               out_committed,
  output logic [cdss_pkg::FULL_YEAR_W-1:0]   out_full_year
);
  import cdss_pkg::*;

  // Input register stage.
  logic                  s1_valid_r;
  op_t                   s1_op_r;
  logic [YEAR_W-1:0]     s1_year_r;
  logic [MONTH_W-1:0]    s1_month_r;
  logic [DAY_W-1:0]      s1_day_r;
  logic [HOUR_W-1:0]     s1_hour_r;
  logic [MINUTE_W-1:0]   s1_minute_r;
  logic [YEAR_W-1:0]     in_year_2d;

  // Edit state; these registers also form the visible result.
  logic                  setup_r,  setup_nxt;
  stage_t                stage_r,  stage_nxt;
  logic [YEAR_W-1:0]     year_r,   year_nxt;
  logic [MONTH_W-1:0]    month_r,  month_nxt;
  logic [DAY_W-1:0]      day_r,    day_nxt;
  logic [HOUR_W-1:0]     hour_r,   hour_nxt;
  logic [MINUTE_W-1:0]   minute_r, minute_nxt;
  logic                  commit_nxt;

  logic                  out_valid_r;
  logic                  out_committed_r;
  logic [FULL_YEAR_W-1:0] out_full_year_r;

  logic                  s1_load;
  logic                  s2_move;
  logic [DAY_W:0]        day_plus1;

  // The second stage moves when it holds an item and the result register is
  // empty or being taken in this cycle.
  assign s2_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign s1_load  = in_valid && !in_stall;

  cdss_mod100 u_mod100 (
    .year_in  (in_cur_year),
    .year_out (in_year_2d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s2_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r     <= op_t'(in_op);
      s1_year_r   <= in_year_2d;
      s1_month_r  <= in_cur_month;
      s1_day_r    <= in_cur_day;
      s1_hour_r   <= in_cur_hour;
      s1_minute_r <= in_cur_minute;
    end
  end

  // Apply one button event to the edit state.
  always_comb begin
    setup_nxt  = setup_r;
    stage_nxt  = stage_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    commit_nxt = 1'b0;
    day_plus1  = {1'b0, day_r} + {{DAY_W{1'b0}}, 1'b1};

    unique case (s1_op_r)
      OP_START: begin
        year_nxt   = s1_year_r;
        month_nxt  = s1_month_r;
        day_nxt    = s1_day_r;
        hour_nxt   = s1_hour_r;
        minute_nxt = s1_minute_r;
        setup_nxt  = 1'b1;
        stage_nxt  = STG_YEAR;
      end
      OP_CANCEL: begin
        setup_nxt = 1'b0;
      end
      OP_INCREASE: begin
        // Each field wraps within its own range.
        unique case (stage_r)
          STG_YEAR: begin
            year_nxt = (year_r >= YEAR_MAX) ? '0 : year_r + 7'd1;
          end
          STG_MONTH: begin
            month_nxt = (month_r >= MONTH_MAX) ? 4'd1 : month_r + 4'd1;
          end
          STG_DAY: begin
            day_nxt = (day_plus1 > {1'b0, month_days(month_r, year_r)}) ? 5'd1
                                                                        : day_plus1[DAY_W-1:0];
          end
          STG_HOUR: begin
            hour_nxt = (hour_r >= HOUR_MAX) ? '0 : hour_r + 5'd1;
          end
          STG_MINUTE: begin
            minute_nxt = (minute_r >= MINUTE_MAX) ? '0 : minute_r + 6'd1;
          end
          default: ;
        endcase
      end
      OP_NEXT: begin
        // Advancing past the minute stage commits and returns to normal
        // mode; the stage stays at minute.
        unique case (stage_r)
          STG_YEAR:   stage_nxt = STG_MONTH;
          STG_MONTH:  stage_nxt = STG_DAY;
          STG_DAY:    stage_nxt = STG_HOUR;
          STG_HOUR:   stage_nxt = STG_MINUTE;
          STG_MINUTE: begin
            setup_nxt  = 1'b0;
            commit_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r  <= 1'b0;
      stage_r  <= STG_YEAR;
      year_r   <= '0;
      month_r  <= 4'd1;
      day_r    <= 5'd1;
      hour_r   <= '0;
      minute_r <= '0;
    end else if (s2_move) begin
      setup_r  <= setup_nxt;
      stage_r  <= stage_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The full year reads zero unless this item committed.
  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_committed_r <= commit_nxt;
      out_full_year_r <= commit_nxt ? (YEAR_BASE + {{(FULL_YEAR_W-YEAR_W){1'b0}}, year_nxt})
                                    : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_setup_active = setup_r;
  assign out_stage        = stage_r;
  assign out_edit_year    = year_r;
  assign out_edit_month   = month_r;
  assign out_edit_day     = day_r;
  assign out_edit_hour    = hour_r;
  assign out_edit_minute  = minute_r;
  assign out_committed    = out_committed_r;
  assign out_full_year    = out_full_year_r;

endmodule

/* tb/tb_clock_date_setting_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the clock date and time setting sequencer.
module tb_clock_date_setting_sequencer;
  import cdss_pkg::*;

  // Run limit in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Random items queued after the directed part.
  localparam int unsigned RANDOM_ITEMS = 1550;
  // Cycles allowed after the last expected result before the verdict.
  localparam int unsigned DRAIN_CYCLES = 12;
  // At most this many mismatch lines are printed; all are counted.
  localparam int unsigned MAX_REPORTS = 40;

  // Receiver stall styles, each held for a random stretch of cycles.
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  // One button event as it is driven onto the input ports.
  typedef struct packed {
    op_t                   op;
    logic [CUR_YEAR_W-1:0] year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
  } button_item_t;

  // Edit registers and mode of the clock setting machine.
  typedef struct {
    logic                setup;
    stage_t              stage;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } edit_state_t;

  // What the block shows on its result ports after one button event.
  typedef struct {
    logic                   setup_active;
    logic [2:0]             stage;
    logic [YEAR_W-1:0]      year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_W-1:0]       day;
    logic [HOUR_W-1:0]      hour;
    logic [MINUTE_W-1:0]    minute;
    logic                   committed;
    logic [FULL_YEAR_W-1:0] full_year;
  } clock_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every input starts at a known value.
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_op = 2'd0;
  logic [CUR_YEAR_W-1:0] in_cur_year = '0;
  logic [MONTH_W-1:0]    in_cur_month = '0;
  logic [DAY_W-1:0]      in_cur_day = '0;
  logic [HOUR_W-1:0]     in_cur_hour = '0;
  logic [MINUTE_W-1:0]   in_cur_minute = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_setup_active;
  logic [2:0]             out_stage;
  logic [YEAR_W-1:0]      out_edit_year;
  logic [MONTH_W-1:0]     out_edit_month;
  logic [DAY_W-1:0]       out_edit_day;
  logic [HOUR_W-1:0]      out_edit_hour;
  logic [MINUTE_W-1:0]    out_edit_minute;
  logic                   out_committed;
  logic [FULL_YEAR_W-1:0] out_full_year;

  // Button events waiting to be driven, and the views they must produce,
  // oldest first.
  button_item_t pending_buttons[$];
  clock_view_t  expected_views[$];
  button_item_t held_button;
  edit_state_t  clock_edit;

  int unsigned cycle_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned starts_seen = 0;
  int unsigned commits_seen = 0;
  int unsigned cancels_seen = 0;
  int unsigned day_wraps_seen = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_style = STALL_NONE;
  int stall_stretch_left = 0;

  clock_date_setting_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_cur_year      (in_cur_year),
    .in_cur_month     (in_cur_month),
    .in_cur_day       (in_cur_day),
    .in_cur_hour      (in_cur_hour),
    .in_cur_minute    (in_cur_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_setup_active (out_setup_active),
    .out_stage        (out_stage),
    .out_edit_year    (out_edit_year),
    .out_edit_month   (out_edit_month),
    .out_edit_day     (out_edit_day),
    .out_edit_hour    (out_edit_hour),
    .out_edit_minute  (out_edit_minute),
    .out_committed    (out_committed),
    .out_full_year    (out_full_year)
  );

  always #5 clk = ~clk;

  // Length of the month being edited. A month code outside 1..12 gets 31
  // days, and February is a leap month whenever the two-digit year is a
  // multiple of four.
  function automatic int days_in_edit_month(logic [MONTH_W-1:0] month,
                                            logic [YEAR_W-1:0] year);
    int len;
    case (month)
      4'd2:                 len = (year % 4 == 0) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      default:              len = 31;
    endcase
    return len;
  endfunction

  // Applies one button event to the predicted edit state and returns the
  // view the block must show afterwards.
  function automatic clock_view_t apply_button(button_item_t btn);
    clock_view_t view;
    logic        commit;
    commit = 1'b0;
    case (btn.op)
      OP_START: begin
        clock_edit.year   = YEAR_W'(btn.year % 100);
        clock_edit.month  = btn.month;
        clock_edit.day    = btn.day;
        clock_edit.hour   = btn.hour;
        clock_edit.minute = btn.minute;
        clock_edit.setup  = 1'b1;
        clock_edit.stage  = STG_YEAR;
        starts_seen++;
      end
      OP_CANCEL: begin
        clock_edit.setup = 1'b0;
        cancels_seen++;
      end
      OP_INCREASE: begin
        // Only the field of the current stage moves; each wraps in its range.
        case (clock_edit.stage)
          STG_YEAR:
            clock_edit.year = YEAR_W'((int'(clock_edit.year) + 1) % 100);
          STG_MONTH:
            clock_edit.month = (clock_edit.month >= 12) ? 4'd1 : clock_edit.month + 4'd1;
          STG_DAY: begin
            if (int'(clock_edit.day) + 1 >
                days_in_edit_month(clock_edit.month, clock_edit.year)) begin
              clock_edit.day = 5'd1;
              day_wraps_seen++;
            end else begin
              clock_edit.day = clock_edit.day + 5'd1;
            end
          end
          STG_HOUR:
            clock_edit.hour = (clock_edit.hour >= 23) ? 5'd0 : clock_edit.hour + 5'd1;
          STG_MINUTE:
            clock_edit.minute = (clock_edit.minute >= 59) ? 6'd0 : clock_edit.minute + 6'd1;
          default: ;
        endcase
      end
      default: begin
        // Next advances the stage in either mode; at the minute stage it
        // commits and drops back to normal mode, staying at minute.
        if (clock_edit.stage == STG_MINUTE) begin
          clock_edit.setup = 1'b0;
          commit = 1'b1;
          commits_seen++;
        end else begin
          clock_edit.stage = stage_t'(clock_edit.stage + 3'd1);
        end
      end
    endcase
    view.setup_active = clock_edit.setup;
    view.stage        = clock_edit.stage;
    view.year         = clock_edit.year;
    view.month        = clock_edit.month;
    view.day          = clock_edit.day;
    view.hour         = clock_edit.hour;
    view.minute       = clock_edit.minute;
    view.committed    = commit;
    view.full_year    = commit ? FULL_YEAR_W'(2000 + int'(clock_edit.year)) : '0;
    return view;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] mismatch on result %0d: %s", $time, checked_count, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic queue_button(op_t op, int unsigned year, int unsigned month,
                              int unsigned day, int unsigned hour, int unsigned minute);
    button_item_t btn;
    btn.op     = op;
    btn.year   = CUR_YEAR_W'(year);
    btn.month  = MONTH_W'(month);
    btn.day    = DAY_W'(day);
    btn.hour   = HOUR_W'(hour);
    btn.minute = MINUTE_W'(minute);
    pending_buttons.push_back(btn);
  endtask

  // The date fields are ignored by everything but start, so they carry
  // random bits on the other events.
  task automatic queue_op(op_t op);
    queue_button(op, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Start with a plausible current date, or now and then with any bits at
  // all in every field.
  task automatic queue_start();
    if ($urandom_range(0, 4) == 0)
      queue_op(OP_START);
    else
      queue_button(OP_START, $urandom_range(0, 9999), $urandom_range(1, 12),
                   $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59));
  endtask

  // Sender: bursts of back-to-back items separated by random gaps. Valid
  // stays up with the same payload until the item is taken, and each
  // accepted item is run through the predictor right away.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_views.push_back(apply_button(held_button));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_buttons.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          in_valid <= 1'b0;
        end else begin
          held_button = pending_buttons.pop_front();
          in_valid      <= 1'b1;
          in_op         <= held_button.op;
          in_cur_year   <= held_button.year;
          in_cur_month  <= held_button.month;
          in_cur_day    <= held_button.day;
          in_cur_hour   <= held_button.hour;
          in_cur_minute <= held_button.minute;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Some bursts are long, and some have no gap at all after them.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest expectation,
  // then picks the next stall value from a style that changes every so
  // often, including stretches with no stall at all.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        clock_view_t want;
        want = expected_views.pop_front();
        check_field("setup_active", out_setup_active, want.setup_active);
        check_field("stage", out_stage, want.stage);
        check_field("edit_year", out_edit_year, want.year);
        check_field("edit_month", out_edit_month, want.month);
        check_field("edit_day", out_edit_day, want.day);
        check_field("edit_hour", out_edit_hour, want.hour);
        check_field("edit_minute", out_edit_minute, want.minute);
        check_field("committed", out_committed, want.committed);
        check_field("full_year", out_full_year, want.full_year);
      end
      checked_count++;
    end
    if (stall_stretch_left == 0) begin
      stall_style = $urandom_range(STALL_NONE, STALL_PERIODIC);
      stall_stretch_left = $urandom_range(16, 160);
    end else begin
      stall_stretch_left--;
    end
    case (stall_style)
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= (cycle_count % 7 < 3);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Watchdog: a result that never shows up ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_views.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int roll;
    int reps;
    int stg;
    int unsigned stop_at;

    // Predicted state after reset: normal mode, year stage, 00-01-01 00:00.
    clock_edit.setup  = 1'b0;
    clock_edit.stage  = STG_YEAR;
    clock_edit.year   = '0;
    clock_edit.month  = 4'd1;
    clock_edit.day    = 5'd1;
    clock_edit.hour   = '0;
    clock_edit.minute = '0;

    // Directed part. Increase and next act before any start, in normal mode.
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);
    queue_op(OP_CANCEL);
    // Largest plausible year reduces to 99, which then wraps to 0; year 0
    // makes February a leap month, so day 28 steps to 29 and then to 1.
    queue_button(OP_START, 9999, 2, 28, 23, 59);
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    // Commit, then next again in normal mode commits a second time.
    queue_op(OP_NEXT);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    // All-zero start: month 0 at the day stage counts as 31 days.
    queue_button(OP_START, 0, 0, 0, 0, 0);
    queue_op(OP_NEXT);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    queue_op(OP_CANCEL);
    // All-ones start: every field but the reduced year is out of range, and each increase wraps one.
    queue_button(OP_START, 16383, 15, 31, 31, 63);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);
    queue_op(OP_INCREASE);
    queue_op(OP_NEXT);

    // Random part. Most of it is whole setting sessions with random
    // content; long runs of increases push day and minute past their wrap.
    // The rest is noise with any op and any field bits.
    stop_at = pending_buttons.size() + RANDOM_ITEMS;
    while (pending_buttons.size() < stop_at) begin
      if ($urandom_range(0, 99) < 75) begin
        queue_start();
        for (stg = 0; stg < 5; stg++) begin
          roll = $urandom_range(0, 99);
          reps = (roll < 15) ? $urandom_range(0, 61) : $urandom_range(0, 3);
          repeat (reps) queue_op(OP_INCREASE);
          if ($urandom_range(0, 99) < 4) begin
            queue_op(OP_CANCEL);
            break;
          end
          queue_op(OP_NEXT);
        end
        if ($urandom_range(0, 9) == 0)
          queue_op(OP_NEXT);
      end else begin
        repeat ($urandom_range(1, 6)) queue_op(op_t'($urandom_range(0, 3)));
      end
    end

    // Synchronous reset, applied once.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item has been taken, then until every result is in.
    while (pending_buttons.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_views.size() != 0)
      @(posedge clk);
    // Anything the block emits after this point shows up as unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_views.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_views.size()));

    $display("Checked %0d results for %0d items in %0d cycles, %0d mismatches.",
             checked_count, accepted_count, cycle_count, mismatch_count);
    $display("Sessions started %0d, commits %0d, cancels %0d, day wraps %0d.",
             starts_seen, commits_seen, cancels_seen, day_wraps_seen);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
